>>> sv/sspr_pkg.sv
package sspr_pkg;

   localparam int SLOT_COUNT  = 12;
   localparam int SLOT_W      = 4;
   localparam int COL_W       = 4;
   localparam int TOKEN_W     = 16;
   localparam int PLANE_COUNT = 8;
   localparam int WORD_W      = 32;
   localparam int RSP_W       = 40;

   localparam int SRC_ROWS    = 35;
   localparam int SRC_STEP    = 27;
   localparam int PITCH       = 16;
   localparam int ROW_OFFSET  = 7;   // screen row 31 is bit 7 of page 3
   localparam int GLYPH_INSET = 3;

   localparam logic [TOKEN_W-1:0] TOKEN_DOT   = 16'h002E;
   localparam logic [TOKEN_W-1:0] TOKEN_MINUS = 16'h002D;
   localparam logic [TOKEN_W-1:0] TOKEN_ZERO  = 16'h0030;
   localparam logic [TOKEN_W-1:0] TOKEN_NINE  = 16'h0039;
   localparam logic [TOKEN_W-1:0] TOKEN_C     = 16'h0043;
   localparam logic [TOKEN_W-1:0] TOKEN_E     = 16'h0045;
   localparam logic [TOKEN_W-1:0] TOKEN_L     = 16'h004C;
   localparam logic [TOKEN_W-1:0] TOKEN_O     = 16'h004F;

   localparam logic [TOKEN_W-1:0] GHE_CODE_RESET   = 16'hFFFE;
   localparam logic [TOKEN_W-1:0] ARROW_CODE_RESET = 16'hFFFF;

   localparam logic [7:0] MASK_MINUS = 8'h40;
   localparam logic [7:0] MASK_L     = 8'h38;
   localparam logic [7:0] MASK_C     = 8'h39;
   localparam logic [7:0] MASK_E     = 8'h79;
   localparam logic [7:0] MASK_GHE   = 8'h31;
   localparam logic [7:0] LEAD_MARK  = 8'h18;

   localparam logic [COL_W-1:0] ARROW_TIP_COL = 4'd9;
   localparam logic [COL_W-1:0] LAST_COL      = 4'd15;

   typedef enum logic [0:0] {
      CSR_GHE_CODE   = 1'b0,
      CSR_ARROW_CODE = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]      slot;
      logic [PLANE_COUNT-1:0] planes;  // bit 7: decimal point, bits 6..0: segments
      logic                   arrow;
      logic                   lead;
   } slot_job_type;

   localparam logic [15:0] SEG_ROWS [PLANE_COUNT][SRC_ROWS] = '{
      '{0: 16'h07E0, 1: 16'h0FE0, 2: 16'h1FC0, default: 16'h0000},
      '{2: 16'h0002, 3: 16'h0006, 4: 16'h000E, 5: 16'h000E, 6: 16'h001E,
        7: 16'h001E, 8: 16'h001C, 9: 16'h003C, 10: 16'h003C, 11: 16'h001C,
        default: 16'h0000},
      '{17: 16'h0008, 18: 16'h0018, 19: 16'h0070, 20: 16'h0070, 21: 16'h00F0,
        22: 16'h00F0, 23: 16'h00F0, 24: 16'h00E0, 25: 16'h00E0, 26: 16'h0060,
        27: 16'h0060, default: 16'h0000},
      '{25: 16'hE000, 26: 16'hFE00, 27: 16'hFE00, 28: 16'h7F00, default: 16'h0000},
      '{17: 16'h6000, 18: 16'h7000, 19: 16'hF000, 20: 16'hF000, 21: 16'hE000,
        22: 16'hE000, default: 16'h0000},
      '{5: 16'h1C00, 6: 16'h3C00, 7: 16'h3C00, 8: 16'h3C00, 9: 16'h3800,
        10: 16'h7000, 11: 16'h4000, default: 16'h0000},
      '{13: 16'h07C0, 14: 16'h1FE0, 15: 16'h0FC0, default: 16'h0000},
      '{28: 16'h0003, 29: 16'h0003, 30: 16'h0003, 31: 16'h0007, 32: 16'h0007,
        33: 16'h0007, 34: 16'h0007, default: 16'h0000}
   };

   // Scale every plane onto the 16 screen columns of a slot, four pages per column.
   function automatic logic [PLANE_COUNT-1:0][PITCH-1:0][WORD_W-1:0] build_seg_cols();
      logic [PLANE_COUNT-1:0][PITCH-1:0][WORD_W-1:0] tab;
      int y;
      int sc;
      tab = '0;
      for (int s = 0; s < PLANE_COUNT; s++) begin
         for (int r = 0; r < SRC_ROWS; r++) begin
            y = ROW_OFFSET + (r * PITCH + SRC_STEP / 2) / SRC_STEP;
            for (int c = 0; c < PITCH; c++) begin
               if (SEG_ROWS[s][r][PITCH-1-c]) begin
                  sc = GLYPH_INSET + (c * PITCH + SRC_STEP / 2) / SRC_STEP;
                  tab[s][sc][y] = 1'b1;
               end
            end
         end
      end
      return tab;
   endfunction

   localparam logic [PLANE_COUNT-1:0][PITCH-1:0][WORD_W-1:0] SEG_COLS = build_seg_cols();

   localparam logic [7:0] DIGIT_MASKS [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // Page 4 byte of the arrow glyph, by slot column.
   localparam logic [7:0] ARROW_PAGE4 [PITCH] = '{
      3: 8'h00, 4: 8'h38, 5: 8'h38, 6: 8'h38, 7: 8'h38, 8: 8'h38,
      9: 8'h39, 10: 8'hBA, 11: 8'h54, 12: 8'h38, default: 8'h00
   };

   function automatic logic [7:0] seg_mask(input logic [TOKEN_W-1:0] t,
                                           input logic [TOKEN_W-1:0] ghe);
      logic [7:0] m;
      m = '0;
      if (t >= TOKEN_ZERO && t <= TOKEN_NINE) m = DIGIT_MASKS[t[3:0]];
      else if (t == TOKEN_O)                  m = DIGIT_MASKS[0];
      else if (t == TOKEN_MINUS)              m = MASK_MINUS;
      else if (t == TOKEN_L)                  m = MASK_L;
      else if (t == TOKEN_C)                  m = MASK_C;
      else if (t == TOKEN_E)                  m = MASK_E;
      else if (t == ghe)                      m = MASK_GHE;
      return m;
   endfunction

   function automatic slot_job_type make_job(input logic [SLOT_W-1:0]  slot,
                                             input logic [TOKEN_W-1:0] t,
                                             input logic               dot,
                                             input logic               lead,
                                             input logic [TOKEN_W-1:0] ghe,
                                             input logic [TOKEN_W-1:0] arrow);
      slot_job_type j;
      logic [7:0] m;
      m = (t == arrow) ? 8'h00 : seg_mask(t, ghe);
      j.slot   = slot;
      j.planes = {dot, m[6:0]};
      j.arrow  = (t == arrow);
      j.lead   = lead && (slot == '0);
      return j;
   endfunction

   function automatic logic [WORD_W-1:0] column_bits(input slot_job_type j,
                                                     input logic [COL_W-1:0] col);
      logic [WORD_W-1:0] w;
      w = '0;
      for (int s = 0; s < PLANE_COUNT; s++) begin
         if (j.planes[s]) w = w | SEG_COLS[s][col];
      end
      if (j.arrow) begin
         w[15:8] = w[15:8] | ARROW_PAGE4[col];
         if (col == ARROW_TIP_COL) w[16] = 1'b1;
      end
      if (j.lead && col <= 4'd1) w[31:24] = w[31:24] | LEAD_MARK;
      return w;
   endfunction

endpackage

>>> sv/seven_segment_page_renderer.sv
// Seven-segment page renderer: draws one indicator row into 16-column digit slots
// on pages 3 to 6 of a page-organised LCD.
// req channel: one display token per transfer (tdata = token, tlast = last cell of
//    the row). A digit slot is held back until the next non-dot token or the row's
//    last token, so a following '.' can add the decimal point to it.
// rsp channel: one transfer per screen column (tdata = column, page 3..6 bytes;
//    tlast marks the final column caused by one token).
// csr channel: register writes (index 0: Ghe token code, index 1: arrow token
//    code), taken in any cycle, legal only while the block is idle.
// Rate: a token that emits nothing leaves req_tready high. A token that emits
//    n slots (0 to 2) keeps req_tready low until its last column is registered:
//    one shared column generator builds one column per cycle unless rsp stalls,
//    using the scaled segment tables. The sequencer registers the job first.
// Stall: a stalled rsp transfer holds the column generator; nothing is dropped.
//    The next token may be taken while the final column still waits.
// Reset: clears the row state, the sequencer state and rsp_tvalid, and loads
//    the register reset codes 0xFFFE (Ghe) and 0xFFFF (arrow).
module seven_segment_page_renderer #(
   parameter int SlotCount = sspr_pkg::SLOT_COUNT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [15:0]             req_tdata,   // [15:0] token
   input  logic                    req_tlast,   // last_token
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,   // [7:0] column, [15:8] page 3,
                                                // [23:16] page 4, [31:24] page 5,
                                                // [39:32] page 6
   output logic                    rsp_tlast,   // last_column
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  sspr_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_data
);
   import sspr_pkg::*;

   // configuration
   logic [TOKEN_W-1:0] ghe_code_ff,   ghe_code_in;
   logic [TOKEN_W-1:0] arrow_code_ff, arrow_code_in;

   // row state
   logic [TOKEN_W-1:0] held_token_ff,  held_token_in;
   logic               held_valid_ff,  held_valid_in;
   logic               held_dot_ff,    held_dot_in;
   logic [SLOT_W-1:0]  slot_count_ff,  slot_count_in;
   logic               leading_dot_ff, leading_dot_in;
   logic               row_full_ff,    row_full_in;

   // sequencer
   state_type          state_ff,      state_in;
   slot_job_type       cur_job_ff,    cur_job_in;
   slot_job_type       next_job_ff,   next_job_in;
   logic               next_valid_ff, next_valid_in;
   logic [COL_W-1:0]   col_ff,        col_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff,  rsp_data_in;
   logic               rsp_last_ff,  rsp_last_in;

   logic               req_fire;
   logic               is_dot;
   logic [SLOT_W-1:0]  held_slot;
   logic               have_a, have_b;
   slot_job_type       job_a, job_b;
   logic [WORD_W-1:0]  col_word;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign is_dot    = (req_tdata == TOKEN_DOT);
   assign held_slot = slot_count_ff - SLOT_W'(1);
   assign col_word  = column_bits(cur_job_ff, col_ff);

   // register writes
   always_comb begin
      ghe_code_in   = ghe_code_ff;
      arrow_code_in = arrow_code_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GHE_CODE:   ghe_code_in   = csr_data;
            CSR_ARROW_CODE: arrow_code_in = csr_data;
         endcase
      end
   end

   // token handling: update the row state and plan up to two slots to draw
   always_comb begin
      held_token_in  = held_token_ff;
      held_valid_in  = held_valid_ff;
      held_dot_in    = held_dot_ff;
      slot_count_in  = slot_count_ff;
      leading_dot_in = leading_dot_ff;
      row_full_in    = row_full_ff;
      have_a         = 1'b0;
      have_b         = 1'b0;
      job_a          = '0;
      job_b          = '0;

      if (req_fire) begin
         if (!row_full_ff) begin
            if (is_dot) begin
               if (slot_count_ff == '0) leading_dot_in = 1'b1;
               else if (held_valid_ff)  held_dot_in    = 1'b1;
               if (req_tlast) begin
                  if (held_valid_ff) begin
                     // flush the held slot with its new decimal point
                     have_a = 1'b1;
                     job_a  = make_job(held_slot, held_token_ff, 1'b1, leading_dot_ff,
                                       ghe_code_ff, arrow_code_ff);
                  end else if (slot_count_ff == '0) begin
                     // row of dots only: blank slot 0 carrying the leading mark
                     have_a      = 1'b1;
                     job_a.slot  = '0;
                     job_a.lead  = 1'b1;
                  end
               end
            end else if (slot_count_ff >= SLOT_W'(SlotCount)) begin
               // overflow: flush and ignore the rest of the row
               have_a        = held_valid_ff;
               job_a         = make_job(held_slot, held_token_ff, held_dot_ff,
                                        leading_dot_ff, ghe_code_ff, arrow_code_ff);
               held_valid_in = 1'b0;
               held_dot_in   = 1'b0;
               row_full_in   = 1'b1;
            end else begin
               have_a = held_valid_ff;
               job_a  = make_job(held_slot, held_token_ff, held_dot_ff, leading_dot_ff,
                                 ghe_code_ff, arrow_code_ff);
               if (held_valid_ff && held_slot == '0) leading_dot_in = 1'b0;
               held_token_in = req_tdata;
               held_valid_in = 1'b1;
               held_dot_in   = 1'b0;
               slot_count_in = slot_count_ff + SLOT_W'(1);
               // last token of the row: the new slot goes out right behind
               have_b = req_tlast;
               job_b  = make_job(slot_count_ff, req_tdata, 1'b0, leading_dot_ff,
                                 ghe_code_ff, arrow_code_ff);
            end
         end
         if (req_tlast) begin
            held_token_in  = '0;
            held_valid_in  = 1'b0;
            held_dot_in    = 1'b0;
            slot_count_in  = '0;
            leading_dot_in = 1'b0;
            row_full_in    = 1'b0;
         end
      end
   end

   // column sequencer and output register
   always_comb begin
      state_in      = state_ff;
      cur_job_in    = cur_job_ff;
      next_job_in   = next_job_ff;
      next_valid_in = next_valid_ff;
      col_in        = col_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (have_a || have_b)) begin
               state_in      = ST_EMIT;
               cur_job_in    = have_a ? job_a : job_b;
               next_job_in   = job_b;
               next_valid_in = have_a && have_b;
               col_in        = '0;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {col_word, cur_job_ff.slot, col_ff};
               rsp_last_in  = (col_ff == LAST_COL) && !next_valid_ff;
               col_in       = col_ff + COL_W'(1);
               if (col_ff == LAST_COL) begin
                  if (next_valid_ff) begin
                     cur_job_in    = next_job_ff;
                     next_valid_in = 1'b0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_valid_ff <= next_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghe_code_ff    <= GHE_CODE_RESET;
         arrow_code_ff  <= ARROW_CODE_RESET;
         held_token_ff  <= '0;
         held_valid_ff  <= 1'b0;
         held_dot_ff    <= 1'b0;
         slot_count_ff  <= '0;
         leading_dot_ff <= 1'b0;
         row_full_ff    <= 1'b0;
      end else begin
         ghe_code_ff    <= ghe_code_in;
         arrow_code_ff  <= arrow_code_in;
         held_token_ff  <= held_token_in;
         held_valid_ff  <= held_valid_in;
         held_dot_ff    <= held_dot_in;
         slot_count_ff  <= slot_count_in;
         leading_dot_ff <= leading_dot_in;
         row_full_ff    <= row_full_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff  <= cur_job_in;
      next_job_ff <= next_job_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> sv/sspr_checker.sv
module sspr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled column holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled column changed");

   // no token is taken while a slot is still being drawn
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("token taken in the middle of a slot");

   // the final column of a token is always the right edge of a slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == 4'd15)
      else $error("final column is not a slot edge");

   // the right edge of a slot is a blank gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == 4'd15 |-> rsp_tdata[39:8] == 32'd0)
      else $error("pixels drawn in the slot gap");

endmodule

bind seven_segment_page_renderer sspr_checker u_sspr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> test/tb_seven_segment_page_renderer.sv
`timescale 1ns / 1ps

module tb_seven_segment_page_renderer;
   import sspr_pkg::*;

   // Geometry of one digit slot: 16 screen columns, glyph scaled by 16/27.
   localparam int COLS_PER_SLOT  = 16;
   localparam int SCALE_DIV      = 27;
   localparam int BITMAP_ROWS    = 35;
   localparam int GLYPH_TOP_ROW  = 31;
   localparam int COL_INSET      = 3;
   localparam int POINT_PLANE    = 7;
   localparam logic [7:0] LEAD_MARK_BITS = 8'h18;
   localparam logic [7:0] ARROW_TIP_BIT  = 8'h01;
   localparam int ARROW_TIP      = 9;
   // Cycles to let pass once the column queue is empty, before a register write.
   localparam int DRAIN_CYCLES   = 40;

   // Segment bitmaps: planes a..g, then the decimal point.
   localparam logic [15:0] SEG_BITMAP [8][BITMAP_ROWS] = '{
      '{0: 16'h07E0, 1: 16'h0FE0, 2: 16'h1FC0, default: 16'h0000},
      '{2: 16'h0002, 3: 16'h0006, 4: 16'h000E, 5: 16'h000E, 6: 16'h001E,
        7: 16'h001E, 8: 16'h001C, 9: 16'h003C, 10: 16'h003C, 11: 16'h001C,
        default: 16'h0000},
      '{17: 16'h0008, 18: 16'h0018, 19: 16'h0070, 20: 16'h0070, 21: 16'h00F0,
        22: 16'h00F0, 23: 16'h00F0, 24: 16'h00E0, 25: 16'h00E0, 26: 16'h0060,
        27: 16'h0060, default: 16'h0000},
      '{25: 16'hE000, 26: 16'hFE00, 27: 16'hFE00, 28: 16'h7F00,
        default: 16'h0000},
      '{17: 16'h6000, 18: 16'h7000, 19: 16'hF000, 20: 16'hF000, 21: 16'hE000,
        22: 16'hE000, default: 16'h0000},
      '{5: 16'h1C00, 6: 16'h3C00, 7: 16'h3C00, 8: 16'h3C00, 9: 16'h3800,
        10: 16'h7000, 11: 16'h4000, default: 16'h0000},
      '{13: 16'h07C0, 14: 16'h1FE0, 15: 16'h0FC0, default: 16'h0000},
      '{28: 16'h0003, 29: 16'h0003, 30: 16'h0003, 31: 16'h0007, 32: 16'h0007,
        33: 16'h0007, 34: 16'h0007, default: 16'h0000}
   };

   localparam logic [7:0] DIGIT_SEGS [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // Page 4 byte of the arrow, from the first glyph column on.
   localparam logic [7:0] ARROW_P4 [10] = '{
      8'h00, 8'h38, 8'h38, 8'h38, 8'h38, 8'h38, 8'h39, 8'hBA, 8'h54, 8'h38
   };

   // How a directed token is checked: predictor, typed result, or no columns at all.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_LEAD_ONLY,
      CHK_BLANK
   } check_kind_type;

   typedef struct packed {
      logic [15:0]    tok;
      logic           last;
      check_kind_type kind;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] col;
      logic [7:0] p3;
      logic [7:0] p4;
      logic [7:0] p5;
      logic [7:0] p6;
      logic       last;
   } column_result_type;

   // Directed rows: blanks, leading marks, each non-digit glyph, overflow, dot handling.
   localparam directed_row_type DIR_ROWS [25] = '{
      '{16'h0041,         1'b1, CHK_BLANK},     // blank glyph alone in a row
      '{TOKEN_DOT,        1'b0, CHK_NONE},      // leading mark, nothing drawn yet
      '{TOKEN_DOT,        1'b1, CHK_LEAD_ONLY}, // row of dots only
      '{16'h0038,         1'b0, CHK_NONE},      // first digit is held back
      '{TOKEN_DOT,        1'b0, CHK_NONE},      // point joins the held slot
      '{ARROW_CODE_RESET, 1'b0, CHK_MODEL},
      '{TOKEN_DOT,        1'b0, CHK_NONE},      // point on the arrow slot
      '{TOKEN_O,          1'b0, CHK_MODEL},
      '{TOKEN_MINUS,      1'b0, CHK_MODEL},
      '{TOKEN_E,          1'b0, CHK_MODEL},
      '{TOKEN_C,          1'b0, CHK_MODEL},
      '{TOKEN_L,          1'b0, CHK_MODEL},
      '{GHE_CODE_RESET,   1'b0, CHK_MODEL},
      '{TOKEN_ZERO,       1'b0, CHK_MODEL},
      '{TOKEN_NINE,       1'b0, CHK_MODEL},
      '{16'h0000,         1'b0, CHK_MODEL},
      '{16'h0031,         1'b0, CHK_MODEL},     // takes the twelfth slot
      '{16'h0032,         1'b0, CHK_MODEL},     // overflow flushes the twelfth
      '{TOKEN_DOT,        1'b0, CHK_NONE},      // ignored once the row is full
      '{16'h7FFF,         1'b1, CHK_NONE},      // row end with nothing held
      '{TOKEN_DOT,        1'b0, CHK_NONE},
      '{16'h0033,         1'b1, CHK_MODEL},     // lead mark merged into slot 0
      '{16'h0034,         1'b0, CHK_NONE},
      '{TOKEN_DOT,        1'b0, CHK_NONE},
      '{16'h8000,         1'b1, CHK_MODEL}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [15:0] token
   logic                  req_tlast;   // last_token
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;   // [7:0] column, [15:8] page 3, [23:16] page 4,
                                       // [31:24] page 5, [39:32] page 6
   logic                  rsp_tlast;   // last_column
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [15:0]           csr_data;

   // Predictor copy of the registers and the row state.
   logic [15:0]           ghe_code;
   logic [15:0]           arrow_code;
   logic [15:0]           held_tok;
   bit                    held_ok;
   bit                    held_pt;
   int                    slots_used;
   bit                    lead_pt;
   bit                    row_over;

   column_result_type     col_expect_q[$];
   int                    fail_count;
   check_kind_type        cur_check;
   bit                    tx_gaps;
   bit                    rx_stalls;
   int                    rsp_hold_len;

   seven_segment_page_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #60_000_000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] glyph_segments(input logic [15:0] t);
      if (t >= TOKEN_ZERO && t <= TOKEN_NINE) return DIGIT_SEGS[t[3:0]];
      if (t == TOKEN_O)     return DIGIT_SEGS[0];
      if (t == TOKEN_MINUS) return MASK_MINUS;
      if (t == TOKEN_L)     return MASK_L;
      if (t == TOKEN_C)     return MASK_C;
      if (t == TOKEN_E)     return MASK_E;
      if (t == ghe_code)    return MASK_GHE;
      return 8'h00;
   endfunction

   // Draw one slot and queue its 16 columns; the arrow overrides any segment glyph.
   task automatic render_slot(input int slot, input bit glyph, input logic [15:0] t,
                              input bit pt, input bit lead);
      logic [7:0]        pix [COLS_PER_SLOT][4];
      logic [7:0]        mask;
      logic [15:0]       px;
      int                y;
      int                pg;
      int                sc;
      column_result_type cr;
      for (int c = 0; c < COLS_PER_SLOT; c++)
         for (int p = 0; p < 4; p++) pix[c][p] = 8'h00;
      if (glyph && t == arrow_code) begin
         for (int c = 0; c < 10; c++) pix[COL_INSET + c][1] |= ARROW_P4[c];
         pix[ARROW_TIP][2] |= ARROW_TIP_BIT;
      end
      mask = (glyph && t != arrow_code) ? glyph_segments(t) : 8'h00;
      for (int r = 0; r < BITMAP_ROWS; r++) begin
         y  = GLYPH_TOP_ROW + (r * COLS_PER_SLOT + SCALE_DIV / 2) / SCALE_DIV;
         pg = (y / 8) - 3;
         px = pt ? SEG_BITMAP[POINT_PLANE][r] : 16'h0000;
         for (int s = 0; s < 7; s++)
            if (mask[s]) px |= SEG_BITMAP[s][r];
         for (int c = 0; c < COLS_PER_SLOT; c++) begin
            if (px[15 - c]) begin
               sc = (c * COLS_PER_SLOT + SCALE_DIV / 2) / SCALE_DIV;
               pix[COL_INSET + sc][pg][y % 8] = 1'b1;
            end
         end
      end
      if (lead && slot == 0) begin
         pix[0][3] |= LEAD_MARK_BITS;
         pix[1][3] |= LEAD_MARK_BITS;
      end
      for (int c = 0; c < COLS_PER_SLOT; c++) begin
         cr.col  = 8'(slot * COLS_PER_SLOT + c);
         cr.p3   = pix[c][0];
         cr.p4   = pix[c][1];
         cr.p5   = pix[c][2];
         cr.p6   = pix[c][3];
         cr.last = 1'b0;
         col_expect_q.push_back(cr);
      end
   endtask

   task automatic flush_held_slot();
      if (held_ok && slots_used > 0) begin
         render_slot(slots_used - 1, 1'b1, held_tok, held_pt, lead_pt);
         if (slots_used == 1) lead_pt = 1'b0;
      end
      held_ok = 1'b0;
      held_pt = 1'b0;
   endtask

   task automatic clear_row_state();
      held_tok   = 16'h0000;
      held_ok    = 1'b0;
      held_pt    = 1'b0;
      slots_used = 0;
      lead_pt    = 1'b0;
      row_over   = 1'b0;
   endtask

   // Advance the row state by one token; first returns where its columns start.
   task automatic predict_token(input logic [15:0] t, input bit last, output int first);
      column_result_type cr;
      first = col_expect_q.size();
      if (!row_over) begin
         if (t == TOKEN_DOT) begin
            if (slots_used == 0) lead_pt = 1'b1;
            else if (held_ok)    held_pt = 1'b1;
         end else if (slots_used >= SLOT_COUNT) begin
            flush_held_slot();
            row_over = 1'b1;
         end else begin
            flush_held_slot();
            held_tok   = t;
            held_ok    = 1'b1;
            held_pt    = 1'b0;
            slots_used = slots_used + 1;
         end
      end
      if (last) begin
         if (held_ok) flush_held_slot();
         else if (slots_used == 0 && lead_pt) render_slot(0, 1'b0, 16'h0000, 1'b0, 1'b1);
         clear_row_state();
      end
      // Mark the final column caused by this token.
      if (col_expect_q.size() > first) begin
         cr = col_expect_q.pop_back();
         cr.last = 1'b1;
         col_expect_q.push_back(cr);
      end
   endtask

   // Typed expectation for slot 0: blank, with or without the leading mark.
   task automatic push_typed_slot(input bit lead);
      column_result_type cr;
      for (int c = 0; c < COLS_PER_SLOT; c++) begin
         cr.col  = 8'(c);
         cr.p3   = 8'h00;
         cr.p4   = 8'h00;
         cr.p5   = 8'h00;
         cr.p6   = (lead && c < 2) ? LEAD_MARK_BITS : 8'h00;
         cr.last = (c == COLS_PER_SLOT - 1);
         col_expect_q.push_back(cr);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      fail_count++;
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   task automatic check_column(input logic [39:0] data, input logic last);
      column_result_type want;
      if (col_expect_q.size() == 0) begin
         report_mismatch("unexpected column transfer", data, 40'h0);
         return;
      end
      want = col_expect_q.pop_front();
      if (data[7:0] != want.col)
         report_mismatch("column", 40'(data[7:0]), 40'(want.col));
      if (data[15:8] != want.p3)
         report_mismatch("page 3", 40'(data[15:8]), 40'(want.p3));
      if (data[23:16] != want.p4)
         report_mismatch("page 4", 40'(data[23:16]), 40'(want.p4));
      if (data[31:24] != want.p5)
         report_mismatch("page 5", 40'(data[31:24]), 40'(want.p5));
      if (data[39:32] != want.p6)
         report_mismatch("page 6", 40'(data[39:32]), 40'(want.p6));
      if (last != want.last)
         report_mismatch("last column", 40'(last), 40'(want.last));
   endtask

   // Sample every transfer at the rising edge: registers first, then tokens, then columns.
   always @(posedge clock) begin : monitor
      int first;
      if (reset) begin
         ghe_code   = GHE_CODE_RESET;
         arrow_code = ARROW_CODE_RESET;
         clear_row_state();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GHE_CODE:   ghe_code   = csr_data;
               CSR_ARROW_CODE: arrow_code = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_token(req_tdata, req_tlast, first);
            // Typed rows replace what the predictor queued for this token.
            if (cur_check != CHK_MODEL) begin
               while (col_expect_q.size() > first) void'(col_expect_q.pop_back());
               if (cur_check == CHK_LEAD_ONLY)  push_typed_slot(1'b1);
               else if (cur_check == CHK_BLANK) push_typed_slot(1'b0);
            end
         end
         if (rsp_tvalid && rsp_tready) check_column(rsp_tdata, rsp_tlast);
      end
   end

   // ---------------------------------------------------------------- receiver

   // Drive rsp_tready at the falling edge; a hold request stalls for that many cycles.
   initial begin : receiver
      int stall;
      int r;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            stall = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (stall == 0 && rx_stalls) begin
            r = $urandom_range(0, 99);
            if (r < 3)       stall = $urandom_range(10, 40);
            else if (r < 25) stall = $urandom_range(1, 3);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- sender

   function automatic int pick_gap();
      int r;
      if (!tx_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Mostly well-formed row content, with some tokens of arbitrary value.
   function automatic logic [15:0] pick_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return TOKEN_ZERO + 16'($urandom_range(0, 9));
      if (r < 58) return TOKEN_DOT;
      if (r < 63) return TOKEN_O;
      if (r < 68) return TOKEN_MINUS;
      if (r < 73) return TOKEN_E;
      if (r < 78) return TOKEN_C;
      if (r < 83) return TOKEN_L;
      if (r < 88) return ghe_code;
      if (r < 93) return arrow_code;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Offer one token after a random gap and hold it until the transfer.
   task automatic send_token(input logic [15:0] t, input bit last,
                             input check_kind_type kind);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tlast  <= last;
      cur_check  <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_row(input int n);
      logic [15:0] t;
      bit          dots_only;
      dots_only = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < n; i++) begin
         t = dots_only ? TOKEN_DOT : pick_token();
         send_token(t, i == n - 1, CHK_MODEL);
      end
   endtask

   // Drop valid and hold until every queued column has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (col_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int row_len;
      int sent;
      int r;
      int guard;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 16'h0000;
      req_tlast    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_GHE_CODE;
      csr_data     = 16'h0000;
      cur_check    = CHK_MODEL;
      tx_gaps      = 1'b0;
      rx_stalls    = 1'b0;
      rsp_hold_len = 0;
      fail_count   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows under the reset register codes.
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      foreach (DIR_ROWS[i]) send_token(DIR_ROWS[i].tok, DIR_ROWS[i].last, DIR_ROWS[i].kind);

      // Random rows, one register setting per phase.
      for (int ph = 0; ph < 7; ph++) begin
         wait_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
         case (ph)
            1: begin
               // Both codes equal: the arrow takes precedence.
               write_reg(CSR_GHE_CODE, 16'h0000);
               write_reg(CSR_ARROW_CODE, 16'h0000);
            end
            2: begin
               write_reg(CSR_GHE_CODE, 16'hFFFF);
               write_reg(CSR_ARROW_CODE, 16'hFFFE);
            end
            3: begin
               // Ghe shadowed by a digit, arrow shadowed by the point.
               write_reg(CSR_GHE_CODE, TOKEN_ZERO + 16'd5);
               write_reg(CSR_ARROW_CODE, TOKEN_DOT);
            end
            4: begin
               write_reg(CSR_GHE_CODE, 16'h0047);
               write_reg(CSR_ARROW_CODE, 16'h003E);
            end
            5: begin
               // Arrow shadows one digit.
               write_reg(CSR_GHE_CODE, 16'($urandom_range(0, 65535)));
               write_reg(CSR_ARROW_CODE, TOKEN_ZERO + 16'($urandom_range(0, 9)));
            end
            6: begin
               write_reg(CSR_GHE_CODE, GHE_CODE_RESET);
               write_reg(CSR_ARROW_CODE, ARROW_CODE_RESET);
            end
            default: ;
         endcase
         // Long receiver hold while tokens keep coming: the block must back up.
         if (ph == 4) rsp_hold_len = 400;
         sent = 0;
         while (sent < 52) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 80)      row_len = $urandom_range(1, 8);
            else if (r < 95) row_len = $urandom_range(9, 13);
            else             row_len = $urandom_range(13, 18);
            send_row(row_len);
            sent += row_len;
            // Pause the sender now and then until the block has caught up.
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (col_expect_q.size() != 0 && guard < 100_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (col_expect_q.size() != 0)
         report_mismatch("columns never transferred", 40'(col_expect_q.size()), 40'h0);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/sspr_pkg.sv
sv/seven_segment_page_renderer.sv
sv/sspr_checker.sv
test/tb_seven_segment_page_renderer.sv
